// File: rtl/mmbc_pkg.sv
// ----------------------------------------------------------------------------
// mmbc_pkg
// Kind codes, polynomials, masks and byte-wide CRC update functions shared by
// the multi-mode byte CRC block.
// ----------------------------------------------------------------------------
package mmbc_pkg;

  // Width of the kind register and of the running CRC
  localparam int unsigned KindW = 3;
  localparam int unsigned CrcW  = 32;

  // Kind codes
  localparam logic [KindW-1:0] KIND_CRC4_REFL  = 3'd0;
  localparam logic [KindW-1:0] KIND_CRC8       = 3'd1;
  localparam logic [KindW-1:0] KIND_CRC16      = 3'd2;
  localparam logic [KindW-1:0] KIND_CRC24Q     = 3'd3;
  localparam logic [KindW-1:0] KIND_CRC32_INV  = 3'd4;
  localparam logic [KindW-1:0] KIND_CRC32_REFL = 3'd5;

  localparam logic [KindW-1:0] KIND_RESET = KIND_CRC24Q;

  // Polynomials
  localparam logic [CrcW-1:0] POLY_CRC4_REFL  = 32'h0000_0009;
  localparam logic [CrcW-1:0] POLY_CRC8       = 32'h0000_0007;
  localparam logic [CrcW-1:0] POLY_CRC16      = 32'h0000_1021;
  localparam logic [CrcW-1:0] POLY_CRC24Q     = 32'h0086_4cfb;
  localparam logic [CrcW-1:0] POLY_CRC32      = 32'h04c1_1db7;
  localparam logic [CrcW-1:0] POLY_CRC32_REFL = 32'hedb8_8320;

  // Width masks
  localparam logic [CrcW-1:0] MASK4  = 32'h0000_000f;
  localparam logic [CrcW-1:0] MASK8  = 32'h0000_00ff;
  localparam logic [CrcW-1:0] MASK16 = 32'h0000_ffff;
  localparam logic [CrcW-1:0] MASK24 = 32'h00ff_ffff;
  localparam logic [CrcW-1:0] MASK32 = 32'hffff_ffff;

  // MSB-first byte update; shift places the byte under the top of the width
  function automatic logic [CrcW-1:0] msb_update(input logic [CrcW-1:0] crc,
                                                 input logic [7:0]      data,
                                                 input logic [CrcW-1:0] poly,
                                                 input logic [CrcW-1:0] mask,
                                                 input logic [CrcW-1:0] top,
                                                 input logic [4:0]      shift);
    logic [CrcW-1:0] r;
    r = (crc ^ ({24'd0, data} << shift)) & mask;
    for (int i = 0; i < 8; i++) begin
      if ((r & top) != '0) begin
        r = ((r << 1) ^ poly) & mask;
      end else begin
        r = (r << 1) & mask;
      end
    end
    return r;
  endfunction

  // LSB-first (reflected) byte update
  function automatic logic [CrcW-1:0] lsb_update(input logic [CrcW-1:0] crc,
                                                 input logic [7:0]      data,
                                                 input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] r;
    r = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ poly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/mmbc_update.sv
// ----------------------------------------------------------------------------
// mmbc_update
// One-byte CRC update for the selected kind: next register value and the
// masked CRC shown for this byte.
// ----------------------------------------------------------------------------
module mmbc_update (
  input  logic [mmbc_pkg::KindW-1:0] crc_kind_i,
  input  logic [mmbc_pkg::CrcW-1:0]  crc_i,
  input  logic [7:0]                 data_byte_i,
  output logic [mmbc_pkg::CrcW-1:0]  crc_next_o,
  output logic [mmbc_pkg::CrcW-1:0]  crc_value_o
);

  // Kind select; CRC-32 standard kind keeps the register inverted
  always_comb begin
    crc_next_o  = crc_i;
    crc_value_o = '0;
    case (crc_kind_i)
      mmbc_pkg::KIND_CRC4_REFL: begin
        crc_next_o = mmbc_pkg::lsb_update(crc_i & mmbc_pkg::MASK4, data_byte_i,
                                          mmbc_pkg::POLY_CRC4_REFL) & mmbc_pkg::MASK4;
        crc_value_o = crc_next_o;
      end
      mmbc_pkg::KIND_CRC8: begin
        crc_next_o = mmbc_pkg::msb_update(crc_i & mmbc_pkg::MASK8, data_byte_i,
                                          mmbc_pkg::POLY_CRC8, mmbc_pkg::MASK8,
                                          32'h0000_0080, 5'd0);
        crc_value_o = crc_next_o;
      end
      mmbc_pkg::KIND_CRC16: begin
        crc_next_o = mmbc_pkg::msb_update(crc_i & mmbc_pkg::MASK16, data_byte_i,
                                          mmbc_pkg::POLY_CRC16, mmbc_pkg::MASK16,
                                          32'h0000_8000, 5'd8);
        crc_value_o = crc_next_o;
      end
      mmbc_pkg::KIND_CRC24Q: begin
        crc_next_o = mmbc_pkg::msb_update(crc_i & mmbc_pkg::MASK24, data_byte_i,
                                          mmbc_pkg::POLY_CRC24Q, mmbc_pkg::MASK24,
                                          32'h0080_0000, 5'd16);
        crc_value_o = crc_next_o;
      end
      mmbc_pkg::KIND_CRC32_INV: begin
        crc_next_o = mmbc_pkg::msb_update(crc_i ^ mmbc_pkg::MASK32, data_byte_i,
                                          mmbc_pkg::POLY_CRC32, mmbc_pkg::MASK32,
                                          32'h8000_0000, 5'd24) ^ mmbc_pkg::MASK32;
        crc_value_o = crc_next_o;
      end
      mmbc_pkg::KIND_CRC32_REFL: begin
        crc_next_o = mmbc_pkg::lsb_update(crc_i, data_byte_i,
                                          mmbc_pkg::POLY_CRC32_REFL);
        crc_value_o = crc_next_o;
      end
      default: begin
        // unused kind: register held, result zero
        crc_next_o  = crc_i;
        crc_value_o = '0;
      end
    endcase
  end

endmodule

// File: rtl/multi_mode_byte_crc_top.sv
// ----------------------------------------------------------------------------
// multi_mode_byte_crc_top
// Byte-serial CRC engine for CRC-4/8/16/24Q/32 kinds; one CRC result per
// message byte, register cleared after the last byte of a message.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                       Dir  Handshake
//  -------  --------------------------------------------  ---  -----------
//  in       data_byte_i, last_in_message_i                in   valid/ready
//  out      crc_value_o                                   out  valid/ready
//  cfg      cfg_we_i, cfg_wdata_i (crc_kind)              in   write enable
//
//  One item per cycle sustained while the output is not stalled; the result
//  passes through the input register, then the CRC update into the result register.
//  The running CRC and the result register load in the same cycle, so the
//  CRC update loop sets the rate.
//  Reset clears the CRC, the valid flags, and sets the kind to CRC-24Q.
//  A stalled output holds both stages; input ready drops only when both are full and the output is stalled.
//
module multi_mode_byte_crc_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [mmbc_pkg::KindW-1:0]  cfg_wdata_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_in_message_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mmbc_pkg::CrcW-1:0]   crc_value_o
);

  logic [mmbc_pkg::KindW-1:0] kind_q;
  logic                       s1_valid_q, s1_valid_d;
  logic [7:0]                 s1_byte_q;
  logic                       s1_last_q;
  logic                       out_valid_q, out_valid_d;
  logic [mmbc_pkg::CrcW-1:0]  out_crc_q;
  logic [mmbc_pkg::CrcW-1:0]  crc_q, crc_d;
  logic [mmbc_pkg::CrcW-1:0]  crc_next;
  logic [mmbc_pkg::CrcW-1:0]  crc_value;
  logic                       advance;
  logic                       in_take;

  // flow control
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  // kind register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= mmbc_pkg::KIND_RESET;
    end else if (cfg_we_i) begin
      kind_q <= cfg_wdata_i;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_in_message_i;
    end
  end

  // CRC update
  mmbc_update u_update (
    .crc_kind_i  (kind_q),
    .crc_i       (crc_q),
    .data_byte_i (s1_byte_q),
    .crc_next_o  (crc_next),
    .crc_value_o (crc_value)
  );

  // running CRC, cleared after the last byte of a message
  always_comb begin
    crc_d = crc_q;
    if (advance && s1_valid_q) begin
      crc_d = s1_last_q ? '0 : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else begin
      crc_q <= crc_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_crc_q <= crc_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;

endmodule
